@@ design/hlfa_pkg.sv @@
// Shared types, codes and port widths for the hole list fit allocator.
`default_nettype none

package hlfa_pkg;

  // Default table shape
  localparam int MAX_HOLES_DEF = 16;
  localparam int SIZE_BITS_DEF = 16;

  // Fixed widths of the beat fields
  localparam int OP_W     = 2;
  localparam int SIZE_W   = 16;
  localparam int STATUS_W = 2;
  localparam int HIDX_W   = 4;
  localparam int REM_W    = 16;
  localparam int LEFT_W   = 5;
  localparam int POLICY_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ALLOC = 2'd0,
    STAT_NOFIT = 2'd1,
    STAT_DONE  = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  typedef enum logic [POLICY_W-1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2
  } policy_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_OUT  = 2'd2
  } state_e;

  // Broadcast command to every cell of the row
  typedef struct packed {
    logic wr;     // write wdata into the selected cell
    logic shift;  // cells at or above the selected index take their upper neighbour
  } cell_cmd_t;

  // Control half of the candidate that walks along the row
  typedef struct packed {
    logic token;  // candidate is live in this stage
    logic found;  // some earlier cell already fits
  } cand_ctl_t;

endpackage

`default_nettype wire

@@ design/hlfa_ifs.sv @@
// Valid/ready channel interfaces for request and response beats.
`default_nettype none

interface hlfa_req_if;
  logic                        valid;
  logic                        ready;
  logic [hlfa_pkg::OP_W-1:0]   op;
  logic [hlfa_pkg::SIZE_W-1:0] size;

  modport source (output valid, output op, output size, input ready);
  modport sink   (input valid, input op, input size, output ready);
endinterface

interface hlfa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [hlfa_pkg::STATUS_W-1:0] status;
  logic [hlfa_pkg::HIDX_W-1:0]   hole_index;
  logic [hlfa_pkg::REM_W-1:0]    remaining;
  logic [hlfa_pkg::LEFT_W-1:0]   holes_left;

  modport source (output valid, output status, output hole_index, output remaining,
                  output holes_left, input ready);
  modport sink   (input valid, input status, input hole_index, input remaining,
                  input holes_left, output ready);
endinterface

`default_nettype wire

@@ design/hlfa_cell.sv @@
// One table cell: holds a hole size and advances the fit candidate by one stage.
`default_nettype none

module hlfa_cell #(
  parameter int MAX_HOLES = hlfa_pkg::MAX_HOLES_DEF,
  parameter int SIZE_BITS = hlfa_pkg::SIZE_BITS_DEF,
  parameter int CELL_IDX  = 0,
  localparam int IDX_W = $clog2(MAX_HOLES),
  localparam int CNT_W = $clog2(MAX_HOLES + 1)
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire hlfa_pkg::cell_cmd_t        cmd_i,
  input  wire logic [IDX_W-1:0]           sel_idx_i,
  input  wire logic [SIZE_BITS-1:0]       wdata_i,
  input  wire logic [SIZE_BITS-1:0]       req_size_i,
  input  wire logic [hlfa_pkg::POLICY_W-1:0] policy_i,
  input  wire logic [CNT_W-1:0]           count_i,
  input  wire logic [SIZE_BITS-1:0]       nbr_hole_i,
  output logic [SIZE_BITS-1:0]            hole_o,
  input  wire hlfa_pkg::cand_ctl_t        cand_ctl_i,
  input  wire logic [IDX_W-1:0]           cand_idx_i,
  input  wire logic [SIZE_BITS-1:0]       cand_size_i,
  output hlfa_pkg::cand_ctl_t             cand_ctl_o,
  output logic [IDX_W-1:0]                cand_idx_o,
  output logic [SIZE_BITS-1:0]            cand_size_o
);

  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [SIZE_BITS-1:0] hole_q;
  hlfa_pkg::cand_ctl_t  cand_ctl_q;
  logic [IDX_W-1:0]     cand_idx_q;
  logic [SIZE_BITS-1:0] cand_size_q;
  logic                 live;
  logic                 fits;
  logic                 better;
  logic                 take;

  // Decide whether this hole replaces the incoming candidate
  always_comb begin
    live = (MY_CNT < count_i);
    fits = live && (hole_q >= req_size_i);
    case (policy_i)
      hlfa_pkg::POL_BEST:  better = (hole_q < cand_size_i);
      hlfa_pkg::POL_WORST: better = (hole_q > cand_size_i);
      default:             better = 1'b0;
    endcase
    take = fits && (!cand_ctl_i.found || better);
  end

  // Hold the hole; take a write, or the upper neighbour on a removal
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && (sel_idx_i == MY_IDX)) begin
      hole_q <= wdata_i;
    end else if (cmd_i.shift && (MY_IDX >= sel_idx_i)) begin
      hole_q <= nbr_hole_i;
    end
  end

  // Advance the candidate control by one stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_ctl_q <= '0;
    end else begin
      cand_ctl_q.token <= cand_ctl_i.token;
      cand_ctl_q.found <= cand_ctl_i.found | take;
    end
  end

  // Advance the candidate payload while the token passes
  always_ff @(posedge clk_i) begin
    if (cand_ctl_i.token) begin
      cand_idx_q  <= take ? MY_IDX : cand_idx_i;
      cand_size_q <= take ? hole_q : cand_size_i;
    end
  end

  assign hole_o      = hole_q;
  assign cand_ctl_o  = cand_ctl_q;
  assign cand_idx_o  = cand_idx_q;
  assign cand_size_o = cand_size_q;

endmodule

`default_nettype wire

@@ design/hlfa_chain.sv @@
// Row of table cells with the candidate passed from neighbour to neighbour.
`default_nettype none

module hlfa_chain #(
  parameter int MAX_HOLES = hlfa_pkg::MAX_HOLES_DEF,
  parameter int SIZE_BITS = hlfa_pkg::SIZE_BITS_DEF,
  localparam int IDX_W = $clog2(MAX_HOLES),
  localparam int CNT_W = $clog2(MAX_HOLES + 1)
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire hlfa_pkg::cell_cmd_t           cmd_i,
  input  wire logic [IDX_W-1:0]              sel_idx_i,
  input  wire logic [SIZE_BITS-1:0]          wdata_i,
  input  wire logic [SIZE_BITS-1:0]          req_size_i,
  input  wire logic [hlfa_pkg::POLICY_W-1:0] policy_i,
  input  wire logic [CNT_W-1:0]              count_i,
  input  wire logic                          start_i,
  output hlfa_pkg::cand_ctl_t                cand_ctl_o,
  output logic [IDX_W-1:0]                   cand_idx_o,
  output logic [SIZE_BITS-1:0]               cand_size_o
);

  hlfa_pkg::cand_ctl_t  ctl  [MAX_HOLES+1];
  logic [IDX_W-1:0]     idx  [MAX_HOLES+1];
  logic [SIZE_BITS-1:0] size [MAX_HOLES+1];
  logic [SIZE_BITS-1:0] hole [MAX_HOLES];

  // Launch an empty candidate into the first cell
  assign ctl[0].token = start_i;
  assign ctl[0].found = 1'b0;
  assign idx[0]       = '0;
  assign size[0]      = '0;

  for (genvar g = 0; g < MAX_HOLES; g++) begin : g_cell
    logic [SIZE_BITS-1:0] nbr;

    // Top cell refills from itself; it falls outside the count after a removal
    if (g == MAX_HOLES - 1) begin : g_top
      assign nbr = hole[g];
    end else begin : g_mid
      assign nbr = hole[g+1];
    end

    hlfa_cell #(
      .MAX_HOLES (MAX_HOLES),
      .SIZE_BITS (SIZE_BITS),
      .CELL_IDX  (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd_i),
      .sel_idx_i   (sel_idx_i),
      .wdata_i     (wdata_i),
      .req_size_i  (req_size_i),
      .policy_i    (policy_i),
      .count_i     (count_i),
      .nbr_hole_i  (nbr),
      .hole_o      (hole[g]),
      .cand_ctl_i  (ctl[g]),
      .cand_idx_i  (idx[g]),
      .cand_size_i (size[g]),
      .cand_ctl_o  (ctl[g+1]),
      .cand_idx_o  (idx[g+1]),
      .cand_size_o (size[g+1])
    );
  end

  assign cand_ctl_o  = ctl[MAX_HOLES];
  assign cand_idx_o  = idx[MAX_HOLES];
  assign cand_size_o = size[MAX_HOLES];

endmodule

`default_nettype wire

@@ design/hole_list_fit_allocator_top.sv @@
// Top level of the hole list fit allocator: control, count, config and result register.
`default_nettype none

// Free-hole table of up to MAX_HOLES entries kept in a row of cells, one hole per
// cell. One request beat is handled at a time. For load, clear and unused opcodes
// the result register loads as the request is taken, then the response register
// loads once it is free, as the request side becomes ready again. An allocate walks
// a candidate through the row one cell per cycle; its result passes the start
// register, each cell's candidate register, the result register and the response
// register. The shrink or removal of the chosen hole lands in the same edge as the
// result register. A finished response waits in its own register, and the next
// request is accepted while it waits. The policy register may be written only while
// no request is in flight.
module hole_list_fit_allocator_top #(
  parameter int MAX_HOLES = hlfa_pkg::MAX_HOLES_DEF,
  parameter int SIZE_BITS = hlfa_pkg::SIZE_BITS_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  hlfa_req_if.sink                           req_i,
  hlfa_rsp_if.source                         rsp_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [hlfa_pkg::POLICY_W-1:0] cfg_wdata_i
);

  localparam int IDX_W = $clog2(MAX_HOLES);
  localparam int CNT_W = $clog2(MAX_HOLES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_HOLES);

  hlfa_pkg::state_e                  state_q, state_d;
  logic [hlfa_pkg::POLICY_W-1:0]     policy_q;
  logic [CNT_W-1:0]                  count_q, count_d;
  logic [SIZE_BITS-1:0]              req_size_q, req_size_d;
  logic                              start_q, start_d;
  logic [hlfa_pkg::STATUS_W-1:0]     res_status_q, res_status_d;
  logic [IDX_W-1:0]                  res_idx_q, res_idx_d;
  logic [SIZE_BITS-1:0]              res_rem_q, res_rem_d;
  logic [CNT_W-1:0]                  res_left_q, res_left_d;
  logic                              res_ld;
  logic                              out_valid_q, out_valid_d;
  logic [hlfa_pkg::STATUS_W-1:0]     out_status_q;
  logic [hlfa_pkg::HIDX_W-1:0]       out_idx_q;
  logic [hlfa_pkg::REM_W-1:0]        out_rem_q;
  logic [hlfa_pkg::LEFT_W-1:0]       out_left_q;
  logic                              accept;
  logic                              out_load;
  logic [31:0]                       size_ext;
  logic [SIZE_BITS-1:0]              in_size;
  logic [31:0]                       idx_ext;
  logic [31:0]                       rem_ext;
  logic [31:0]                       left_ext;
  hlfa_pkg::cell_cmd_t               cmd;
  logic [IDX_W-1:0]                  sel_idx;
  logic [SIZE_BITS-1:0]              wdata;
  hlfa_pkg::cand_ctl_t               cand_ctl;
  logic [IDX_W-1:0]                  cand_idx;
  logic [SIZE_BITS-1:0]              cand_size;

  // Handshakes and input size folded to the table width
  assign accept   = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == hlfa_pkg::S_IDLE);
  assign out_load = (state_q == hlfa_pkg::S_OUT) && (!out_valid_q || rsp_o.ready);
  assign size_ext = 32'(req_i.size);
  assign in_size  = size_ext[SIZE_BITS-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hlfa_pkg::S_IDLE: begin
        if (accept) begin
          state_d = (req_i.op == hlfa_pkg::OP_ALLOC) ? hlfa_pkg::S_SCAN : hlfa_pkg::S_OUT;
        end
      end
      hlfa_pkg::S_SCAN: begin
        if (cand_ctl.token) begin
          state_d = hlfa_pkg::S_OUT;
        end
      end
      hlfa_pkg::S_OUT: begin
        if (out_load) begin
          state_d = hlfa_pkg::S_IDLE;
        end
      end
      default: state_d = hlfa_pkg::S_IDLE;
    endcase
  end

  // Table commands, count update and pending result
  always_comb begin
    cmd          = '0;
    sel_idx      = '0;
    wdata        = in_size;
    count_d      = count_q;
    req_size_d   = req_size_q;
    start_d      = 1'b0;
    res_ld       = 1'b0;
    res_status_d = hlfa_pkg::STAT_NOFIT;
    res_idx_d    = '0;
    res_rem_d    = '0;
    res_left_d   = count_q;
    unique case (state_q)
      hlfa_pkg::S_IDLE: begin
        if (accept) begin
          case (req_i.op)
            hlfa_pkg::OP_LOAD: begin
              res_ld = 1'b1;
              if (count_q >= CNT_FULL) begin
                res_status_d = hlfa_pkg::STAT_FULL;
              end else begin
                cmd.wr       = 1'b1;
                sel_idx      = count_q[IDX_W-1:0];
                count_d      = count_q + CNT_W'(1);
                res_status_d = hlfa_pkg::STAT_DONE;
                res_idx_d    = count_q[IDX_W-1:0];
                res_left_d   = count_q + CNT_W'(1);
              end
            end
            hlfa_pkg::OP_ALLOC: begin
              req_size_d = in_size;
              start_d    = 1'b1;
            end
            hlfa_pkg::OP_CLEAR: begin
              res_ld       = 1'b1;
              count_d      = '0;
              res_status_d = hlfa_pkg::STAT_DONE;
              res_left_d   = '0;
            end
            default: begin
              res_ld = 1'b1;
            end
          endcase
        end
      end
      hlfa_pkg::S_SCAN: begin
        if (cand_ctl.token) begin
          res_ld = 1'b1;
          if (cand_ctl.found) begin
            res_status_d = hlfa_pkg::STAT_ALLOC;
            res_idx_d    = cand_idx;
            sel_idx      = cand_idx;
            if (cand_size == req_size_q) begin
              // exact fit: drop the hole and close the gap
              cmd.shift  = 1'b1;
              count_d    = count_q - CNT_W'(1);
              res_left_d = count_q - CNT_W'(1);
            end else begin
              cmd.wr    = 1'b1;
              wdata     = cand_size - req_size_q;
              res_rem_d = cand_size - req_size_q;
            end
          end
        end
      end
      hlfa_pkg::S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // Response register: load a finished result, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q && !rsp_o.ready;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign idx_ext  = 32'(res_idx_q);
  assign rem_ext  = 32'(res_rem_q);
  assign left_ext = 32'(res_left_q);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hlfa_pkg::S_IDLE;
      policy_q    <= hlfa_pkg::POL_FIRST;
      count_q     <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        policy_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_size_q <= req_size_d;
    if (res_ld) begin
      res_status_q <= res_status_d;
      res_idx_q    <= res_idx_d;
      res_rem_q    <= res_rem_d;
      res_left_q   <= res_left_d;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_idx_q    <= idx_ext[hlfa_pkg::HIDX_W-1:0];
      out_rem_q    <= rem_ext[hlfa_pkg::REM_W-1:0];
      out_left_q   <= left_ext[hlfa_pkg::LEFT_W-1:0];
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.hole_index = out_idx_q;
  assign rsp_o.remaining  = out_rem_q;
  assign rsp_o.holes_left = out_left_q;

  hlfa_chain #(
    .MAX_HOLES (MAX_HOLES),
    .SIZE_BITS (SIZE_BITS)
  ) u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sel_idx_i   (sel_idx),
    .wdata_i     (wdata),
    .req_size_i  (req_size_q),
    .policy_i    (policy_q),
    .count_i     (count_q),
    .start_i     (start_q),
    .cand_ctl_o  (cand_ctl),
    .cand_idx_o  (cand_idx),
    .cand_size_o (cand_size)
  );

  // Count never passes the table depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("hole count beyond table depth");

  // A candidate leaves the row only while a scan is running
  a_token_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cand_ctl.token |-> state_q == hlfa_pkg::S_SCAN)
    else $error("candidate left the row outside a scan");

  // A start pulse appears only in a scan launched by an accepted allocate beat
  a_start_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> (state_q == hlfa_pkg::S_SCAN) && $past(accept))
    else $error("scan start without an allocate beat");

  // Removal only happens on a found exact fit
  a_shift_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.shift |-> cand_ctl.found && (count_q != '0))
    else $error("removal without a fitting hole");

endmodule

`default_nettype wire
